>>> src/dqr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the DNS query-to-reply rewriter.
// No dependencies; imported by dqr_ctrl, dqr_datapath and the top level.
package dqr_pkg;

   typedef enum logic [1:0] {
      RSP_READY = 2'd0,
      RSP_DROP  = 2'd1,
      RSP_BYTE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_HOST_IP    = 2'd0,
      CSR_NAME_LEN   = 2'd1,
      CSR_CHARS_LOW  = 2'd2,
      CSR_CHARS_HIGH = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_LOAD     = 4'd1,
      OP_PULL_RD  = 4'd2,
      OP_LEN_RD   = 4'd3,
      OP_LEN_CHK  = 4'd4,
      OP_NAME     = 4'd5,
      OP_WALK     = 4'd6,
      OP_TC       = 4'd7,
      OP_PULL_OUT = 4'd8
   } op_type;

   typedef struct packed {
      op_type op;
      logic   build;
      logic   clear;
   } cmd_type;

   typedef struct packed {
      logic pending;
      logic len_bad;
      logic cand;
      logic name_end;
      logic walk_zero;
      logic walk_over;
      logic tc_over;
      logic tc_last;
      logic ans_over;
   } stat_type;

   typedef struct packed {
      logic       valid;
      status_type status;
   } emit_type;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       matched_host;
      logic [8:0] reply_length;
      logic       reply_last;
   } payload_type;

   localparam int          NameMax       = 16;
   localparam int          FirstLenAt    = 12;
   localparam int          NameAt        = 13;
   localparam int          LabelLimit    = 63;
   localparam int          QuestionTail  = 4;
   localparam int          AnsBytes      = 16;
   localparam logic [7:0]  FlagsOr       = 8'h84;
   localparam logic [7:0]  RcodeNotImp   = 8'h04;
   localparam logic [31:0] LoopbackIp    = 32'h7f00_0001;
   localparam logic [31:0] TypeClassAIn  = 32'h0001_0001;

   function automatic logic [7:0] name_char(input logic [3:0] idx,
                                            input logic [63:0] lo,
                                            input logic [63:0] hi);
      logic [63:0] w;
      w = idx[3] ? hi : lo;
      return w[{idx[2:0], 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] ans_byte(input logic [3:0] k, input logic [31:0] ip);
      logic [7:0] b;
      case (k)
         4'd0:    b = 8'hc0;
         4'd1:    b = 8'h0c;
         4'd2:    b = 8'h00;
         4'd3:    b = 8'h01;
         4'd4:    b = 8'h00;
         4'd5:    b = 8'h01;
         4'd6:    b = 8'h00;
         4'd7:    b = 8'h00;
         4'd8:    b = 8'h02;
         4'd9:    b = 8'h58;
         4'd10:   b = 8'h00;
         4'd11:   b = 8'h04;
         4'd12:   b = ip[31:24];
         4'd13:   b = ip[23:16];
         4'd14:   b = ip[15:8];
         4'd15:   b = ip[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> src/dqr_datapath.sv
`timescale 1ns / 1ps
// Datapath: packet store, config registers, label walk and reply overlay logic.
// Depends on dqr_pkg; driven by dqr_ctrl through cmd_type commands.
module dqr_datapath #(
   parameter int BUFFER_BYTES = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic [7:0]           load_byte,
   input  dqr_pkg::cmd_type     cmd,
   output dqr_pkg::stat_type    stat,
   output dqr_pkg::payload_type payload
);
   import dqr_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int PW = $clog2(BUFFER_BYTES + 257);
   localparam logic [PW-1:0] BufEnd = PW'(BUFFER_BYTES);

   logic [7:0]    packet_mem [BUFFER_BYTES];

   logic [31:0]   host_ip_ff;
   logic [4:0]    hlen_ff;
   logic [63:0]   chars_lo_ff, chars_hi_ff;

   logic [7:0]    rd_data_ff;
   logic          rd_ok_ff, rd_ok_in;
   logic [CW-1:0] load_count_ff, load_count_in;
   logic [CW-1:0] reply_count_ff, reply_count_in;
   logic [CW-1:0] rp_ff, rp_in;
   logic          pending_ff, pending_in;
   logic [7:0]    byte2_ff, byte2_in;
   logic [5:0]    len_ff, len_in;
   logic [3:0]    idx_ff, idx_in;
   logic          match_ff, match_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [23:0]   tc_ff, tc_in;
   logic [1:0]    tcidx_ff, tcidx_in;
   logic          a_in_ff, a_in_in;
   logic [CW-1:0] ans_base_ff, ans_base_in;
   logic [31:0]   ip_ff, ip_in;

   logic [7:0]    din, ch, pull_byte;
   logic [PW-1:0] rd_addr, pos_step, pos_inc, rc_new;
   logic [CW-1:0] lc_base, ans_off;
   logic          mem_we, a_in, in_ans, pull_last;
   logic [AW-1:0] wr_addr;
   logic [31:0]   tc_full;

   always_comb begin
      din       = rd_ok_ff ? rd_data_ff : 8'h00;
      ch        = name_char(idx_ff, chars_lo_ff, chars_hi_ff);
      pos_step  = pos_ff + PW'(din) + PW'(1);
      pos_inc   = pos_ff + PW'(1);
      tc_full   = {tc_ff, din};
      a_in      = (tc_full == TypeClassAIn);
      rc_new    = a_in ? pos_ff + PW'(QuestionTail + AnsBytes) : pos_ff + PW'(QuestionTail);
      pull_last = (rp_ff + CW'(1) == reply_count_ff);

      stat.pending   = pending_ff;
      stat.len_bad   = (din == 8'h00) || (din >= 8'(LabelLimit));
      stat.cand      = (din[5:0] == {1'b0, hlen_ff}) && (din[5:0] <= 6'(NameMax));
      stat.name_end  = (din != ch) || (6'(idx_ff) + 6'd1 == len_ff);
      stat.walk_zero = (din == 8'h00);
      stat.walk_over = (pos_step >= BufEnd);
      stat.tc_over   = (pos_inc + PW'(QuestionTail) > BufEnd);
      stat.tc_last   = (tcidx_ff == 2'd3);
      stat.ans_over  = a_in && (pos_ff + PW'(QuestionTail + AnsBytes) > BufEnd);

      ans_off = rp_ff - ans_base_ff;
      in_ans  = a_in_ff && (rp_ff >= ans_base_ff) && (ans_off < CW'(AnsBytes));
      if (in_ans) begin
         pull_byte = ans_byte(ans_off[3:0], ip_ff);
      end else if (rp_ff == CW'(2)) begin
         pull_byte = byte2_ff | FlagsOr;
      end else if (rp_ff == CW'(3) && !a_in_ff) begin
         pull_byte = RcodeNotImp;
      end else if (rp_ff == CW'(6)) begin
         pull_byte = 8'h00;
      end else if (rp_ff == CW'(7)) begin
         pull_byte = {7'b0, a_in_ff};
      end else begin
         pull_byte = din;
      end
   end

   always_comb begin
      load_count_in  = load_count_ff;
      reply_count_in = reply_count_ff;
      rp_in          = rp_ff;
      pending_in     = pending_ff;
      byte2_in       = byte2_ff;
      len_in         = len_ff;
      idx_in         = idx_ff;
      match_in       = match_ff;
      pos_in         = pos_ff;
      tc_in          = tc_ff;
      tcidx_in       = tcidx_ff;
      a_in_in        = a_in_ff;
      ans_base_in    = ans_base_ff;
      ip_in          = ip_ff;
      rd_addr        = '0;
      mem_we         = 1'b0;
      lc_base        = pending_ff ? '0 : load_count_ff;
      wr_addr        = lc_base[AW-1:0];
      payload        = '0;

      case (cmd.op)
         OP_LOAD: begin
            if (pending_ff) begin
               reply_count_in = '0;
               rp_in          = '0;
               pending_in     = 1'b0;
               byte2_in       = 8'h00;
            end
            load_count_in = lc_base;
            if (lc_base < CW'(BUFFER_BYTES)) begin
               mem_we        = 1'b1;
               load_count_in = lc_base + CW'(1);
               if (lc_base == CW'(2)) begin
                  byte2_in = load_byte;
               end
            end
         end
         OP_PULL_RD: begin
            rd_addr = PW'(rp_ff);
         end
         OP_LEN_RD: begin
            rd_addr = PW'(FirstLenAt);
         end
         OP_LEN_CHK: begin
            len_in   = din[5:0];
            idx_in   = '0;
            match_in = stat.cand;
            pos_in   = PW'(FirstLenAt);
            rd_addr  = stat.cand ? PW'(NameAt) : PW'(FirstLenAt);
         end
         OP_NAME: begin
            match_in = match_ff && (din == ch);
            idx_in   = idx_ff + 4'd1;
            rd_addr  = stat.name_end ? PW'(FirstLenAt) : PW'(NameAt) + PW'(idx_ff) + PW'(1);
         end
         OP_WALK: begin
            if (stat.walk_zero) begin
               pos_in   = pos_inc;
               tcidx_in = '0;
               rd_addr  = pos_inc;
            end else begin
               pos_in  = pos_step;
               rd_addr = pos_step;
            end
         end
         OP_TC: begin
            tc_in    = {tc_ff[15:0], din};
            tcidx_in = tcidx_ff + 2'd1;
            rd_addr  = pos_ff + PW'(tcidx_ff) + PW'(1);
         end
         OP_PULL_OUT: begin
            payload.reply_byte = pull_byte;
            payload.reply_last = pull_last;
            rp_in              = rp_ff + CW'(1);
            if (pull_last) begin
               load_count_in  = '0;
               reply_count_in = '0;
               rp_in          = '0;
               pending_in     = 1'b0;
               byte2_in       = 8'h00;
            end
         end
         default: ;
      endcase

      if (cmd.build) begin
         pending_in             = 1'b1;
         rp_in                  = '0;
         reply_count_in         = CW'(rc_new);
         a_in_in                = a_in;
         ans_base_in            = CW'(pos_ff + PW'(QuestionTail));
         ip_in                  = match_ff ? host_ip_ff : LoopbackIp;
         payload.reply_length   = rc_new[8:0];
         payload.matched_host   = match_ff;
      end
      if (cmd.clear) begin
         load_count_in  = '0;
         reply_count_in = '0;
         rp_in          = '0;
         pending_in     = 1'b0;
         byte2_in       = 8'h00;
      end
      rd_ok_in = (rd_addr < PW'(load_count_ff));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         packet_mem[wr_addr] <= load_byte;
      end
      rd_data_ff <= packet_mem[rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         host_ip_ff     <= '0;
         hlen_ff        <= '0;
         chars_lo_ff    <= '0;
         chars_hi_ff    <= '0;
         load_count_ff  <= '0;
         reply_count_ff <= '0;
         rp_ff          <= '0;
         pending_ff     <= 1'b0;
         byte2_ff       <= 8'h00;
         rd_ok_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_HOST_IP:    host_ip_ff  <= csr_wdata[31:0];
               CSR_NAME_LEN:   hlen_ff     <= csr_wdata[4:0];
               CSR_CHARS_LOW:  chars_lo_ff <= csr_wdata;
               CSR_CHARS_HIGH: chars_hi_ff <= csr_wdata;
               default: ;
            endcase
         end
         load_count_ff  <= load_count_in;
         reply_count_ff <= reply_count_in;
         rp_ff          <= rp_in;
         pending_ff     <= pending_in;
         byte2_ff       <= byte2_in;
         rd_ok_ff       <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      match_ff    <= match_in;
      pos_ff      <= pos_in;
      tc_ff       <= tc_in;
      tcidx_ff    <= tcidx_in;
      a_in_ff     <= a_in_in;
      ans_base_ff <= ans_base_in;
      ip_ff       <= ip_in;
   end

endmodule

>>> src/dqr_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: input handshake, label walk sequencing, result issue.
// Depends on dqr_pkg; commands dqr_datapath and reads its status.
module dqr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_mode,
   input  logic              req_last,
   input  logic              rsp_free,
   input  dqr_pkg::stat_type stat,
   output logic              req_tready,
   output dqr_pkg::cmd_type  cmd,
   output dqr_pkg::emit_type emit
);
   import dqr_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PULL   = 7'b0000010,
      ST_LEN_RD = 7'b0000100,
      ST_LEN    = 7'b0001000,
      ST_NAME   = 7'b0010000,
      ST_WALK   = 7'b0100000,
      ST_TC     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.op      = OP_NONE;
      cmd.build   = 1'b0;
      cmd.clear   = 1'b0;
      emit.valid  = 1'b0;
      emit.status = RSP_READY;
      req_tready  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = rsp_free;
            if (req_tvalid && rsp_free) begin
               if (req_mode) begin
                  if (stat.pending) begin
                     cmd.op   = OP_PULL_RD;
                     state_in = ST_PULL;
                  end
               end else begin
                  cmd.op = OP_LOAD;
                  if (req_last) begin
                     state_in = ST_LEN_RD;
                  end
               end
            end
         end
         ST_PULL: begin
            cmd.op      = OP_PULL_OUT;
            emit.valid  = 1'b1;
            emit.status = RSP_BYTE;
            state_in    = ST_IDLE;
         end
         ST_LEN_RD: begin
            cmd.op   = OP_LEN_RD;
            state_in = ST_LEN;
         end
         ST_LEN: begin
            cmd.op = OP_LEN_CHK;
            if (stat.len_bad) begin
               cmd.clear   = 1'b1;
               emit.valid  = 1'b1;
               emit.status = RSP_DROP;
               state_in    = ST_IDLE;
            end else if (stat.cand) begin
               state_in = ST_NAME;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_NAME: begin
            cmd.op = OP_NAME;
            if (stat.name_end) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.op = OP_WALK;
            if (stat.walk_zero ? stat.tc_over : stat.walk_over) begin
               cmd.clear   = 1'b1;
               emit.valid  = 1'b1;
               emit.status = RSP_DROP;
               state_in    = ST_IDLE;
            end else if (stat.walk_zero) begin
               state_in = ST_TC;
            end
         end
         ST_TC: begin
            cmd.op = OP_TC;
            if (stat.tc_last) begin
               emit.valid = 1'b1;
               state_in   = ST_IDLE;
               if (stat.ans_over) begin
                  cmd.clear   = 1'b1;
                  emit.status = RSP_DROP;
               end else begin
                  cmd.build   = 1'b1;
                  emit.status = RSP_READY;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/dns_query_to_reply_rewriter.sv
`timescale 1ns / 1ps
// Top level of the DNS query-to-reply rewriter: ports, result register, submodules.
// Depends on dqr_pkg, dqr_ctrl and dqr_datapath.
//
// Query bytes (req_tuser = 0) are taken one per cycle, while the result register is free,
// into a BUFFER_BYTES-byte packet store with one write and one read port. After req_tlast
// the input stalls while the controller walks the question through the read port, one
// byte per cycle: first label length, hostname compare on equal length, label walk, type
// and class. It then issues a status word (0 reply ready with its length, 1 dropped). Each
// pull word (req_tuser = 1) stalls the input for the registered store read and returns one
// reply byte with status 2. Header and answer rewrites are overlaid on the read, so the
// store holds only the query; bytes past the loaded length read as zero.
// A load while a reply is pending discards it; a pull with no reply pending gives no word.
// The result sits in an output register; the next word is taken as it drains.
module dns_query_to_reply_rewriter #(
   parameter int BUFFER_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] query_byte
   input  logic        req_tuser,   // [0] mode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [8:0] reply_length, [9] matched_host, [17:10] reply_byte
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);
   import dqr_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   emit_type    emit;
   payload_type payload;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;
   logic        rsp_last_ff;
   logic        rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   dqr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_last   (req_tlast),
      .rsp_free   (rsp_free),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd),
      .emit       (emit)
   );

   dqr_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .load_byte (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .payload   (payload)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_data_ff <= {6'b0, payload.reply_byte, payload.matched_host, payload.reply_length};
         rsp_user_ff <= emit.status;
         rsp_last_ff <= payload.reply_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> bench/dns_query_to_reply_rewriter_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for dns_query_to_reply_rewriter: loads DNS queries, pulls the
// replies and checks every status and reply word against a behavioral predictor.
// Depends on dqr_pkg and the block's RTL; needs no files or arguments.
module dns_query_to_reply_rewriter_tb;
   import dqr_pkg::*;

   localparam int StoreBytes  = 256;
   localparam int QuietLimit  = 3000;
   localparam int LongHold    = 300;
   localparam int RandomWords = 800;

   typedef logic [7:0] byte_t;

   typedef struct {
      status_type status;
      logic [8:0] length;
      logic       matched;
      logic [7:0] data;
      logic       last;
   } reply_word_t;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] query_byte
   logic        req_tuser;   // [0] mode
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [8:0] reply_length, [9] matched_host, [17:10] reply_byte
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        rsp_tlast;

   dns_query_to_reply_rewriter dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // shadow of the packet store and registers
   byte_t       pkt_mem [StoreBytes];
   int unsigned load_cnt;
   int unsigned reply_cnt;
   int unsigned rd_ptr;
   bit          reply_pending;
   logic [31:0] cfg_ip;
   logic [4:0]  cfg_name_len;
   logic [63:0] cfg_chars_lo;
   logic [63:0] cfg_chars_hi;

   reply_word_t expected_words[$];
   int unsigned errors;
   int unsigned words_sent;
   bit          tx_idle;
   bit          rx_idle;
   bit          long_hold_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned idle_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   function automatic void clear_shadow();
      foreach (pkt_mem[i]) pkt_mem[i] = '0;
      load_cnt      = 0;
      reply_cnt     = 0;
      rd_ptr        = 0;
      reply_pending = 1'b0;
   endfunction

   function automatic byte_t host_char(int unsigned i);
      logic [127:0] chars;
      chars = {cfg_chars_hi, cfg_chars_lo};
      return chars[i*8 +: 8];
   endfunction

   function automatic bit first_label_hit(int unsigned len);
      if (len != cfg_name_len || len > NameMax) return 1'b0;
      for (int unsigned i = 0; i < len; i++)
         if (pkt_mem[NameAt + i] != host_char(i)) return 1'b0;
      return 1'b1;
   endfunction

   // turns the loaded query into a reply in the shadow store; 0 means dropped
   function automatic bit rewrite_query(output bit hit);
      int unsigned pos;
      logic [31:0] ip;
      byte_t       answer [AnsBytes];
      hit = 1'b0;
      if (pkt_mem[FirstLenAt] == 0 || pkt_mem[FirstLenAt] >= LabelLimit) return 1'b0;
      hit = first_label_hit(pkt_mem[FirstLenAt]);
      pos = FirstLenAt;
      while (pos < StoreBytes && pkt_mem[pos] != 0) pos += pkt_mem[pos] + 1;
      if (pos >= StoreBytes) return 1'b0;
      pos++;
      if (pos + QuestionTail > StoreBytes) return 1'b0;
      if ({pkt_mem[pos], pkt_mem[pos+1], pkt_mem[pos+2], pkt_mem[pos+3]} == TypeClassAIn) begin
         pos += QuestionTail;
         if (pos + AnsBytes > StoreBytes) return 1'b0;
         ip = hit ? cfg_ip : LoopbackIp;
         answer = '{8'hc0, 8'h0c, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
                    8'h02, 8'h58, 8'h00, 8'h04, ip[31:24], ip[23:16], ip[15:8], ip[7:0]};
         foreach (answer[k]) pkt_mem[pos + k] = answer[k];
         pkt_mem[7] = 8'h01;
         pos += AnsBytes;
      end else begin
         pos += QuestionTail;
         pkt_mem[3] = RcodeNotImp;
         pkt_mem[7] = 8'h00;
      end
      pkt_mem[2] = pkt_mem[2] | FlagsOr;
      pkt_mem[6] = 8'h00;
      reply_cnt     = pos;
      rd_ptr        = 0;
      reply_pending = 1'b1;
      return 1'b1;
   endfunction

   function automatic void predict_word(bit pull, byte_t data, bit last);
      reply_word_t w;
      bit          hit;
      w = '{RSP_BYTE, 9'd0, 1'b0, 8'd0, 1'b0};
      if (pull) begin
         if (!reply_pending || rd_ptr >= reply_cnt) return;
         w.data = pkt_mem[rd_ptr];
         w.last = (rd_ptr + 1 == reply_cnt);
         rd_ptr++;
         if (rd_ptr >= reply_cnt) clear_shadow();
      end else begin
         if (reply_pending) clear_shadow();
         if (load_cnt < StoreBytes) begin
            pkt_mem[load_cnt] = data;
            load_cnt++;
         end
         if (!last) return;
         if (rewrite_query(hit)) begin
            w.status  = RSP_READY;
            w.length  = reply_cnt[8:0];
            w.matched = hit;
         end else begin
            clear_shadow();
            w.status = RSP_DROP;
         end
      end
      expected_words.push_back(w);
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         errors++;
      end
   endfunction

   function automatic void check_reply();
      reply_word_t want;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual tuser %h tdata %h tlast %b",
                  $time, rsp_tuser, rsp_tdata, rsp_tlast);
         errors++;
         return;
      end
      want = expected_words.pop_front();
      check_field("status", want.status, rsp_tuser);
      check_field("reply_length", want.length, rsp_tdata[8:0]);
      check_field("matched_host", want.matched, rsp_tdata[9]);
      check_field("reply_byte", want.data, rsp_tdata[17:10]);
      check_field("reply_last", want.last, rsp_tlast);
      check_field("tdata pad", 0, rsp_tdata[23:18]);
   endfunction

   // ---------------- sender side ----------------

   task automatic send_word(input bit pull, input byte_t data, input bit last);
      int unsigned gap;
      gap = (tx_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= pull;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(pull, data, last);
      words_sent++;
   endtask

   task automatic send_query(input byte_t q[$]);
      foreach (q[i]) send_word(1'b0, q[i], i == q.size() - 1);
   endtask

   task automatic pull_words(input int unsigned n);
      repeat (n) send_word(1'b1, 8'($urandom), 1'($urandom));
   endtask

   task automatic drain_reply();
      while (reply_pending) send_word(1'b1, 8'($urandom), 1'($urandom));
   endtask

   task automatic run_query(input byte_t q[$]);
      send_query(q);
      drain_reply();
   endtask

   // finish the open reply and let the block go idle
   task automatic settle();
      drain_reply();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_config(input logic [31:0] ip, input logic [4:0] name_len,
                               input logic [63:0] chars_lo, input logic [63:0] chars_hi);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_HOST_IP;
      csr_wdata <= {$urandom, ip};
      @(posedge clock);
      csr_index <= CSR_NAME_LEN;
      csr_wdata <= ({$urandom, $urandom} & ~64'h1f) | 64'(name_len);
      @(posedge clock);
      csr_index <= CSR_CHARS_LOW;
      csr_wdata <= chars_lo;
      @(posedge clock);
      csr_index <= CSR_CHARS_HIGH;
      csr_wdata <= chars_hi;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_ip       = ip;
      cfg_name_len = name_len;
      cfg_chars_lo = chars_lo;
      cfg_chars_hi = chars_hi;
   endtask

   // ---------------- query builders ----------------

   function automatic void start_query(ref byte_t q[$]);
      q.delete();
      repeat (FirstLenAt) q.push_back(8'($urandom));
   endfunction

   function automatic void put_label(ref byte_t q[$], input int unsigned len);
      q.push_back(8'(len));
      repeat (len) q.push_back(8'($urandom));
   endfunction

   function automatic void put_host_label(ref byte_t q[$]);
      q.push_back(8'(cfg_name_len));
      for (int unsigned i = 0; i < cfg_name_len; i++) q.push_back(host_char(i));
   endfunction

   function automatic void put_tail(ref byte_t q[$], input logic [15:0] qtype,
                                    input logic [15:0] qclass);
      q.push_back(8'h00);
      q.push_back(qtype[15:8]);
      q.push_back(qtype[7:0]);
      q.push_back(qclass[15:8]);
      q.push_back(qclass[7:0]);
   endfunction

   // labels covering exactly span bytes of the name
   function automatic void fill_labels(ref byte_t q[$], input int unsigned span);
      int unsigned len;
      while (span > 0) begin
         len = (span > 63) ? ((span - 63 == 1) ? 61 : 62) : span - 1;
         put_label(q, len);
         span -= len + 1;
      end
   endfunction

   function automatic void spoil_name(ref byte_t q[$]);
      int unsigned at;
      at = NameAt + $urandom_range(0, q[FirstLenAt] - 1);
      q[at] = q[at] ^ (8'h01 << $urandom_range(0, 7));
   endfunction

   function automatic void make_query(ref byte_t q[$]);
      int unsigned pick;
      start_query(q);
      pick = $urandom_range(0, 9);
      if (pick < 7 && cfg_name_len != 0 && cfg_name_len <= NameMax) begin
         put_host_label(q);
         if (pick >= 5) spoil_name(q);
      end else begin
         put_label(q, $urandom_range(1, 20));
      end
      repeat ($urandom_range(0, 2)) put_label(q, $urandom_range(1, 8));
      pick = $urandom_range(0, 9);
      if (pick < 7) put_tail(q, 16'd1, 16'd1);
      else if (pick < 9) put_tail(q, 16'($urandom_range(2, 33)), 16'd1);
      else put_tail(q, 16'($urandom), 16'($urandom));
      if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 11)) q.push_back(8'($urandom));
      pick = $urandom_range(0, 19);
      if (pick == 0) q[FirstLenAt] = 8'h00;
      else if (pick == 1) q[FirstLenAt] = 8'($urandom_range(LabelLimit, 255));
      else if (pick == 2) q = q[0 : $urandom_range(0, q.size() - 2)];
   endfunction

   // ---------------- tests ----------------

   task automatic test_unloaded_pulls();
      byte_t q[$];
      pull_words(3);
      start_query(q);
      put_label(q, 3);
      put_label(q, 3);
      put_tail(q, 16'd1, 16'd1);
      run_query(q);
      pull_words(2);
   endtask

   task automatic test_hostname_compare();
      byte_t q[$];
      write_config(32'hc0a8_0a01, 5'd5, {$urandom, $urandom}, {$urandom, $urandom});
      start_query(q);
      put_host_label(q);
      put_label(q, 3);
      put_tail(q, 16'd1, 16'd1);
      run_query(q);
      start_query(q);
      put_host_label(q);
      spoil_name(q);
      put_tail(q, 16'd1, 16'd1);
      run_query(q);
      // same prefix, one character longer
      start_query(q);
      put_host_label(q);
      q.insert(NameAt + 5, 8'h61);
      q[FirstLenAt] = 8'd6;
      put_tail(q, 16'd1, 16'd1);
      run_query(q);

      write_config($urandom, 5'd16, {$urandom, $urandom}, {$urandom, $urandom});
      start_query(q);
      put_host_label(q);
      put_tail(q, 16'd1, 16'd1);
      run_query(q);
      start_query(q);
      put_host_label(q);
      put_tail(q, 16'd28, 16'd1);
      run_query(q);

      // hostname longer than the compare allows never matches
      write_config($urandom, 5'd31, {$urandom, $urandom}, {$urandom, $urandom});
      start_query(q);
      put_label(q, 31);
      put_tail(q, 16'd1, 16'd1);
      run_query(q);
      write_config($urandom, 5'd0, 64'h0, 64'h0);
      start_query(q);
      put_label(q, 1);
      put_tail(q, 16'd1, 16'd1);
      run_query(q);
   endtask

   task automatic test_bad_first_label();
      byte_t q[$];
      byte_t bad_len[3];
      bad_len = '{8'd0, 8'd63, 8'd255};
      foreach (bad_len[i]) begin
         start_query(q);
         q.push_back(bad_len[i]);
         repeat (5) q.push_back(8'($urandom));
         put_tail(q, 16'd1, 16'd1);
         run_query(q);
      end
      start_query(q);
      put_label(q, 62);
      put_tail(q, 16'd1, 16'd1);
      run_query(q);
   endtask

   task automatic test_question_types();
      byte_t       q[$];
      logic [15:0] kinds[5][2];
      kinds = '{'{16'd15, 16'd1}, '{16'd1, 16'd3}, '{16'h0100, 16'h0100},
                '{16'hffff, 16'hffff}, '{16'd0, 16'd1}};
      foreach (kinds[i]) begin
         start_query(q);
         put_label(q, $urandom_range(1, 10));
         put_tail(q, kinds[i][0], kinds[i][1]);
         run_query(q);
      end
   endtask

   task automatic test_store_limits();
      byte_t q[$];
      // walk runs to the end of the store
      start_query(q);
      fill_labels(q, 244);
      run_query(q);
      // label length jumps past the end
      start_query(q);
      fill_labels(q, 200);
      q.push_back(8'd200);
      repeat (4) q.push_back(8'($urandom));
      run_query(q);
      // type and class do not fit
      start_query(q);
      fill_labels(q, 240);
      put_tail(q, 16'd1, 16'd1);
      run_query(q);
      // answer does not fit, but a non-A reply fills the store exactly
      start_query(q);
      fill_labels(q, 239);
      put_tail(q, 16'd1, 16'd1);
      run_query(q);
      start_query(q);
      fill_labels(q, 239);
      put_tail(q, 16'd2, 16'd1);
      run_query(q);
      // load past the store size
      start_query(q);
      put_label(q, 3);
      put_tail(q, 16'd1, 16'd1);
      while (q.size() < 300) q.push_back(8'($urandom));
      run_query(q);
   endtask

   task automatic test_short_queries();
      byte_t q[$];
      write_config($urandom, 5'd1, 64'h0, 64'h0);
      q.delete();
      q.push_back(8'($urandom));
      run_query(q);
      // label character never loaded reads zero and matches
      start_query(q);
      q.push_back(8'd1);
      run_query(q);
      start_query(q);
      put_label(q, 2);
      run_query(q);
   endtask

   task automatic test_reply_abandon();
      byte_t q[$];
      start_query(q);
      put_label(q, 4);
      put_tail(q, 16'd1, 16'd1);
      send_query(q);
      pull_words(5);
      start_query(q);
      put_label(q, 7);
      put_tail(q, 16'd15, 16'd1);
      send_query(q);
      pull_words(2);
      q.delete();
      q.push_back(8'($urandom));
      send_query(q);
      start_query(q);
      put_label(q, 2);
      put_tail(q, 16'd1, 16'd1);
      run_query(q);
      pull_words(3);
   endtask

   task automatic test_long_holdoff();
      byte_t q[$];
      settle();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      start_query(q);
      fill_labels(q, 223);
      put_tail(q, 16'd1, 16'd1);
      send_query(q);
      long_hold_req = 1'b1;
      drain_reply();
   endtask

   task automatic random_exchange();
      byte_t       q[$];
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         pull_words($urandom_range(1, 3));
      end else if (pick < 10) begin
         q.delete();
         repeat ($urandom_range(1, 40)) q.push_back(8'($urandom));
         send_query(q);
      end else begin
         make_query(q);
         send_query(q);
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            drain_reply();
            if ($urandom_range(0, 4) == 0) pull_words($urandom_range(1, 3));
         end else if (pick < 8) begin
            pull_words($urandom_range(1, 8));
         end
      end
   endtask

   task automatic test_random_traffic();
      int unsigned stop_at;
      for (int unsigned phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_config(32'hffff_ffff, 5'd16, '1, '1);
            1: write_config(32'h0, 5'd1, {$urandom, $urandom}, {$urandom, $urandom});
            2: write_config($urandom, 5'($urandom_range(1, 16)), {$urandom, $urandom},
                            {$urandom, $urandom});
            default: write_config($urandom, 5'($urandom), {$urandom, $urandom},
                                  {$urandom, $urandom});
         endcase
         tx_idle = (phase == 1 || phase == 3);
         rx_idle = (phase >= 2);
         stop_at = words_sent + RandomWords / 4;
         while (words_sent < stop_at) random_exchange();
      end
   endtask

   // ---------------- receiver, checker, watchdog ----------------

   initial begin
      int unsigned hold;
      hold       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_reply();
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = LongHold;
         end else if (hold == 0 && rx_idle && rsp_tready && $urandom_range(0, 3) == 0) begin
            hold = idle_len();
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no word accepted for %0d cycles", $time, QuietLimit);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_HOST_IP;
      csr_wdata     = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      req_tlast     = 1'b0;
      tx_idle       = 1'b1;
      rx_idle       = 1'b1;
      long_hold_req = 1'b0;
      errors        = 0;
      words_sent    = 0;
      cfg_ip        = '0;
      cfg_name_len  = '0;
      cfg_chars_lo  = '0;
      cfg_chars_hi  = '0;
      clear_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unloaded_pulls();
      test_hostname_compare();
      test_bad_first_label();
      test_question_types();
      test_store_limits();
      test_short_queries();
      test_reply_abandon();
      test_long_holdoff();
      test_random_traffic();

      settle();
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
src/dqr_pkg.sv
src/dqr_datapath.sv
src/dqr_ctrl.sv
src/dns_query_to_reply_rewriter.sv
bench/dns_query_to_reply_rewriter_tb.sv
